>>> hdl/gpq_pkg.sv
// ----------------------------------------------------------------------------
// gpq_pkg: shared types and constants of the gamepad event qualifier
// Event encoding, key layout, register map and the shared adder's request.
// ----------------------------------------------------------------------------
package gpq_pkg;

  // Key and channel counts of one controller.
  localparam int KEY_COUNT    = 24;
  localparam int ANALOG_COUNT = 6;

  // Register map: index of each register in the configuration space.
  localparam logic [2:0] REG_LEFT_DZ   = 3'd0;
  localparam logic [2:0] REG_RIGHT_DZ  = 3'd1;
  localparam logic [2:0] REG_TRIG_THR  = 3'd2;
  localparam logic [2:0] REG_INIT_RPT  = 3'd3;
  localparam logic [2:0] REG_RPT_INTVL = 3'd4;

  // Register reset values.
  localparam logic [14:0] LEFT_DZ_RST   = 15'd7849;
  localparam logic [14:0] RIGHT_DZ_RST  = 15'd8689;
  localparam logic [7:0]  TRIG_THR_RST  = 8'd30;
  localparam logic [15:0] INIT_RPT_RST  = 16'd200;
  localparam logic [15:0] RPT_INTVL_RST = 16'd100;

  // Bit position in the button word of each of the ten face/shoulder keys.
  localparam logic [3:0] BTN_POS [10] = '{
    4'd12, 4'd13, 4'd14, 4'd15, 4'd8, 4'd9, 4'd5, 4'd4, 4'd6, 4'd7
  };

  // Kind of one emitted event.
  typedef enum logic [2:0] {
    EV_ANALOG  = 3'd0,
    EV_PRESS   = 3'd1,
    EV_RELEASE = 3'd2,
    EV_REPEAT  = 3'd3,
    EV_NONE    = 3'd4
  } ev_kind_t;

  // One emitted event.
  typedef struct packed {
    ev_kind_t           kind;
    logic [4:0]         key;
    logic [1:0]         ctl;
    logic signed [15:0] value;
    logic               last;
  } event_t;

  // Request from the sequencer to the event buffer.
  typedef struct packed {
    logic   push;
    logic   fin;
    event_t evt;
  } emit_req_t;

  // Room status of the event buffer.
  typedef struct packed {
    logic push_ok;
    logic out_free;
  } emit_sts_t;

  // Shared adder operation.
  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  typedef struct packed {
    alu_op_t     op;
    logic [31:0] a;
    logic [31:0] b;
  } alu_req_t;

  // Forms the 24 digital keys of one poll sample.
  function automatic logic [23:0] form_keys(
    input logic [15:0]        btn,
    input logic [7:0]         lt,
    input logic [7:0]         rt,
    input logic signed [15:0] lx,
    input logic signed [15:0] ly,
    input logic signed [15:0] rx,
    input logic signed [15:0] ry,
    input logic [14:0]        ldz,
    input logic [14:0]        rdz,
    input logic [7:0]         tdz
  );
    logic [23:0]        k;
    logic signed [16:0] lp, ln, rp, rn;
    logic signed [16:0] lxe, lye, rxe, rye;
    k   = '0;
    lp  = $signed({2'b00, ldz});
    ln  = -lp;
    rp  = $signed({2'b00, rdz});
    rn  = -rp;
    lxe = $signed({lx[15], lx});
    lye = $signed({ly[15], ly});
    rxe = $signed({rx[15], rx});
    rye = $signed({ry[15], ry});
    for (int i = 0; i < 10; i++) begin
      k[i] = btn[BTN_POS[i]];
    end
    k[10]    = (lt > tdz);
    k[11]    = (rt > tdz);
    k[15:12] = btn[3:0];
    k[16]    = (lye > lp);
    k[17]    = (lye < ln);
    k[18]    = (lxe < ln);
    k[19]    = (lxe > lp);
    k[20]    = (rye > rp);
    k[21]    = (rye < rn);
    k[22]    = (rxe < rn);
    k[23]    = (rxe > rp);
    return k;
  endfunction

endpackage

>>> hdl/gamepad_event_qualifier.sv
// ----------------------------------------------------------------------------
// gamepad_event_qualifier: gamepad poll sample to key and analog events
// Sequencer that walks the analog channels and the 24 keys of one sample
// through a shared adder and two small memories.
// ----------------------------------------------------------------------------
// Usage: one poll sample enters on the in_ channel (valid/stall). The block
// stalls its input from the accepting edge until the last event of that
// sample has been loaded into the output register. Events leave on the out_
// channel, one per item, in order: analog reports, then press, release and
// repeat events in key order; out_last_event marks the final one of a sample.
// A sample that causes nothing yields one event of kind "no event".
// Sequencing: the single shared adder and the single-port memories set the
// pace; each analog channel and each key takes a read step and an
// evaluation step, and a key whose repeat is due takes a repeat step too.
// An idle or disconnected sample goes straight to the end of the sample.
// A stalled receiver holds the sequencer only when a new event finds both
// the holding stage and the output register full, or when the end of a
// sample finds the output register full.
// Reset (rst_n, synchronous) restores the register defaults, marks every
// controller as disconnected, clears held keys and axis history.
// Configuration (APB, pready always high) must be written only while idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module gamepad_event_qualifier #(
  parameter int CONTROLLER_COUNT = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_controller_index,
  input  logic               in_read_ok,
  input  logic [15:0]        in_button_bits,
  input  logic [7:0]         in_left_trigger,
  input  logic [7:0]         in_right_trigger,
  input  logic signed [15:0] in_left_x,
  input  logic signed [15:0] in_left_y,
  input  logic signed [15:0] in_right_x,
  input  logic signed [15:0] in_right_y,
  input  logic [31:0]        in_now_ticks,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_event_kind,
  output logic [4:0]         out_key_code,
  output logic [1:0]         out_event_controller,
  output logic signed [15:0] out_analog_value,
  output logic               out_last_event
);
  import gpq_pkg::*;

  localparam int CW       = (CONTROLLER_COUNT > 1) ? $clog2(CONTROLLER_COUNT) : 1;
  localparam int PA_DEPTH = CONTROLLER_COUNT * 6;
  localparam int DL_DEPTH = CONTROLLER_COUNT * 24;
  localparam int PA_AW    = $clog2(PA_DEPTH);
  localparam int DL_AW    = $clog2(DL_DEPTH);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_ARD  = 7'b0000010,
    S_AEV  = 7'b0000100,
    S_KRD  = 7'b0001000,
    S_KEV  = 7'b0010000,
    S_KRP  = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  // Configuration registers.
  logic [14:0] ldz_r, rdz_r;
  logic [7:0]  tdz_r;
  logic [15:0] init_r, intv_r;

  // Sequencer control.
  state_t      state_r, state_nxt;
  logic [2:0]  aidx_r, aidx_nxt;
  logic [4:0]  kidx_r, kidx_nxt;
  logic        act_r;
  logic        held_we;

  // Captured sample.
  logic [1:0]         c_r;
  logic signed [15:0] lx_r, ly_r, rx_r, ry_r;
  logic [7:0]         lt_r, rt_r;
  logic [31:0]        now_r;
  logic [23:0]        keys_r;

  // Per-controller link and held keys.
  logic              link_up_r [CONTROLLER_COUNT];
  logic [23:0]       held_r    [CONTROLLER_COUNT];

  logic        in_acc, in_range, in_act;
  logic [CW-1:0] in_cidx, cidx_r;
  logic        cfg_wr;

  // Memory and adder connections.
  logic               pa_rd, pa_we, dl_rd, dl_we;
  logic [7:0]         pa_full;
  logic [9:0]         dl_full;
  logic signed [15:0] pa_rdata;
  logic [31:0]        dl_rdata, dl_wdata;
  alu_req_t           alu_req;
  logic [31:0]        alu_res;
  emit_req_t          emit_req;
  emit_sts_t          emit_sts;
  event_t             out_evt;

  // Channel under evaluation.
  logic signed [15:0] cur_val;
  logic [14:0]        cur_dz;
  logic [15:0]        cur_abs;
  logic               was_held, now_key;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  // Register read-back.
  always_comb begin
    case (paddr[4:2])
      REG_LEFT_DZ:   prdata = {17'd0, ldz_r};
      REG_RIGHT_DZ:  prdata = {17'd0, rdz_r};
      REG_TRIG_THR:  prdata = {24'd0, tdz_r};
      REG_INIT_RPT:  prdata = {16'd0, init_r};
      REG_RPT_INTVL: prdata = {16'd0, intv_r};
      default:       prdata = 32'd0;
    endcase
  end

  // Input handshake and sample qualification.
  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign in_cidx  = CW'(in_controller_index);
  assign in_range = (int'(in_controller_index) < CONTROLLER_COUNT);
  assign in_act   = in_range && link_up_r[in_cidx] && in_read_ok;
  assign cidx_r   = CW'(c_r);

  // Memory addresses: controller * 6 + channel, controller * 24 + key.
  assign pa_full = {4'd0, c_r, 2'b00} + {5'd0, c_r, 1'b0} + {5'd0, aidx_r};
  assign dl_full = {4'd0, c_r, 4'd0} + {5'd0, c_r, 3'd0} + {5'd0, kidx_r};

  // Value and deadzone of the current analog channel.
  always_comb begin
    case (aidx_r)
      3'd0:    cur_val = lx_r;
      3'd1:    cur_val = ly_r;
      3'd2:    cur_val = rx_r;
      3'd3:    cur_val = ry_r;
      3'd4:    cur_val = $signed({8'd0, lt_r});
      3'd5:    cur_val = $signed({8'd0, rt_r});
      default: cur_val = 16'sd0;
    endcase
    case (aidx_r)
      3'd0, 3'd1: cur_dz = ldz_r;
      3'd2, 3'd3: cur_dz = rdz_r;
      default:    cur_dz = {7'd0, tdz_r};
    endcase
  end

  assign cur_abs  = cur_val[15] ? (~cur_val + 16'd1) : cur_val;
  assign was_held = held_r[cidx_r][kidx_r];
  assign now_key  = keys_r[kidx_r];

  // Operands of the shared adder per step.
  always_comb begin
    alu_req.op = ALU_ADD;
    alu_req.a  = 32'd0;
    alu_req.b  = 32'd0;
    case (state_r)
      S_AEV: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = {17'd0, cur_dz};
        alu_req.b  = {16'd0, cur_abs};
      end
      S_KEV: begin
        if (!was_held && now_key) begin
          alu_req.op = ALU_ADD;
          alu_req.b  = {16'd0, init_r};
        end else begin
          alu_req.op = ALU_SUB;
          alu_req.b  = dl_rdata;
        end
        alu_req.a = now_r;
      end
      S_KRP: begin
        alu_req.op = ALU_ADD;
        alu_req.a  = now_r;
        alu_req.b  = {16'd0, intv_r};
      end
      default: begin
        alu_req.op = ALU_ADD;
      end
    endcase
  end

  gpq_alu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  assign dl_wdata = alu_res;

  // Sequencer: analog channels, then keys, then the end of the sample; an inactive sample goes straight to the end.
  always_comb begin
    state_nxt          = state_r;
    aidx_nxt           = aidx_r;
    kidx_nxt           = kidx_r;
    pa_rd              = 1'b0;
    pa_we              = 1'b0;
    dl_rd              = 1'b0;
    dl_we              = 1'b0;
    held_we            = 1'b0;
    emit_req.push      = 1'b0;
    emit_req.fin       = 1'b0;
    emit_req.evt.kind  = EV_NONE;
    emit_req.evt.key   = 5'd0;
    emit_req.evt.ctl   = c_r;
    emit_req.evt.value = 16'sd0;
    emit_req.evt.last  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          aidx_nxt  = 3'd0;
          kidx_nxt  = 5'd0;
          state_nxt = in_act ? S_ARD : S_DONE;
        end
      end
      S_ARD: begin
        pa_rd     = 1'b1;
        state_nxt = S_AEV;
      end
      S_AEV: begin
        // Report when changed or outside the deadzone (dz - |v| negative).
        emit_req.evt.kind  = EV_ANALOG;
        emit_req.evt.key   = 5'(KEY_COUNT) + {2'd0, aidx_r};
        emit_req.evt.value = cur_val;
        if (!(((pa_rdata != cur_val) || alu_res[31]) && !emit_sts.push_ok)) begin
          emit_req.push = (pa_rdata != cur_val) || alu_res[31];
          pa_we         = 1'b1;
          if (aidx_r == 3'(ANALOG_COUNT - 1)) begin
            state_nxt = S_KRD;
          end else begin
            aidx_nxt  = aidx_r + 3'd1;
            state_nxt = S_ARD;
          end
        end
      end
      S_KRD: begin
        dl_rd     = 1'b1;
        state_nxt = S_KEV;
      end
      S_KEV: begin
        emit_req.evt.key  = kidx_r;
        emit_req.evt.kind = now_key ? EV_PRESS : EV_RELEASE;
        if (was_held != now_key) begin
          if (emit_sts.push_ok) begin
            emit_req.push = 1'b1;
            dl_we         = now_key;
            if (kidx_r == 5'(KEY_COUNT - 1)) begin
              state_nxt = S_DONE;
            end else begin
              kidx_nxt  = kidx_r + 5'd1;
              state_nxt = S_KRD;
            end
          end
        end else if (was_held && !alu_res[31]) begin
          // Deadline reached, wrap-safe: take the repeat step.
          state_nxt = S_KRP;
        end else if (kidx_r == 5'(KEY_COUNT - 1)) begin
          state_nxt = S_DONE;
        end else begin
          kidx_nxt  = kidx_r + 5'd1;
          state_nxt = S_KRD;
        end
      end
      S_KRP: begin
        emit_req.evt.key  = kidx_r;
        emit_req.evt.kind = EV_REPEAT;
        if (emit_sts.push_ok) begin
          emit_req.push = 1'b1;
          dl_we         = 1'b1;
          if (kidx_r == 5'(KEY_COUNT - 1)) begin
            state_nxt = S_DONE;
          end else begin
            kidx_nxt  = kidx_r + 5'd1;
            state_nxt = S_KRD;
          end
        end
      end
      S_DONE: begin
        if (emit_sts.out_free) begin
          emit_req.fin = 1'b1;
          held_we      = act_r;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state, link tracking, held keys and configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      aidx_r  <= 3'd0;
      kidx_r  <= 5'd0;
      act_r   <= 1'b0;
      ldz_r   <= LEFT_DZ_RST;
      rdz_r   <= RIGHT_DZ_RST;
      tdz_r   <= TRIG_THR_RST;
      init_r  <= INIT_RPT_RST;
      intv_r  <= RPT_INTVL_RST;
      for (int i = 0; i < CONTROLLER_COUNT; i++) begin
        link_up_r[i] <= 1'b0;
        held_r[i]    <= 24'd0;
      end
    end else begin
      state_r <= state_nxt;
      aidx_r  <= aidx_nxt;
      kidx_r  <= kidx_nxt;
      if (in_acc) begin
        act_r <= in_act;
        if (in_range) begin
          link_up_r[in_cidx] <= in_read_ok;
        end
      end
      if (held_we) begin
        held_r[cidx_r] <= keys_r;
      end
      if (cfg_wr) begin
        case (paddr[4:2])
          REG_LEFT_DZ:   ldz_r  <= pwdata[14:0];
          REG_RIGHT_DZ:  rdz_r  <= pwdata[14:0];
          REG_TRIG_THR:  tdz_r  <= pwdata[7:0];
          REG_INIT_RPT:  init_r <= pwdata[15:0];
          REG_RPT_INTVL: intv_r <= pwdata[15:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Sample capture; keys are formed with the current thresholds.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      c_r    <= in_controller_index;
      lx_r   <= in_left_x;
      ly_r   <= in_left_y;
      rx_r   <= in_right_x;
      ry_r   <= in_right_y;
      lt_r   <= in_left_trigger;
      rt_r   <= in_right_trigger;
      now_r  <= in_now_ticks;
      keys_r <= form_keys(in_button_bits, in_left_trigger, in_right_trigger,
                          in_left_x, in_left_y, in_right_x, in_right_y,
                          ldz_r, rdz_r, tdz_r);
    end
  end

  gpq_store #(
    .CONTROLLER_COUNT (CONTROLLER_COUNT)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .pa_rd    (pa_rd),
    .pa_we    (pa_we),
    .pa_addr  (pa_full[PA_AW-1:0]),
    .pa_wdata (cur_val),
    .pa_rdata (pa_rdata),
    .dl_rd    (dl_rd),
    .dl_we    (dl_we),
    .dl_addr  (dl_full[DL_AW-1:0]),
    .dl_wdata (dl_wdata),
    .dl_rdata (dl_rdata)
  );

  gpq_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (emit_req),
    .sts       (emit_sts),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_evt   (out_evt)
  );

  // Result ports.
  assign out_event_kind       = out_evt.kind;
  assign out_key_code         = out_evt.key;
  assign out_event_controller = out_evt.ctl;
  assign out_analog_value     = out_evt.value;
  assign out_last_event       = out_evt.last;

  // An event is only handed over when the buffer has room for it.
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    emit_req.push |-> emit_sts.push_ok)
    else $error("event pushed without room in the event buffer");

  // Closing a sample always lands a last event in the output register.
  a_fin_last: assert property (@(posedge clk) disable iff (!rst_n)
    emit_req.fin |=> (out_valid && out_last_event))
    else $error("end of sample did not present a last event");

  // An accepted item keeps the input stalled on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after an accepted item");

  // No memory write while no sample is being processed.
  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !(pa_we || dl_we || held_we))
    else $error("state written while idle");

  // Held keys change only at the end of an active sample.
  a_held_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    held_we |-> (act_r && emit_req.fin))
    else $error("held keys written outside the end of an active sample");

endmodule

>>> hdl/gpq_alu.sv
// ----------------------------------------------------------------------------
// gpq_alu: shared 32-bit add/subtract unit
// Serves deadzone compares, wrap-safe deadline checks and deadline updates.
// ----------------------------------------------------------------------------
module gpq_alu (
  input  gpq_pkg::alu_req_t req,
  output logic [31:0]       res
);
  import gpq_pkg::*;

  logic [31:0] b_op;

  // Subtraction is an add of the inverted operand with a carry in.
  assign b_op = (req.op == ALU_SUB) ? ~req.b : req.b;
  assign res  = req.a + b_op + {31'd0, (req.op == ALU_SUB)};

endmodule

>>> hdl/gpq_store.sv
// ----------------------------------------------------------------------------
// gpq_store: per-controller axis history and repeat deadline memories
// Single-port memories with registered read data; axis history reads as zero
// until an entry is first written.
// ----------------------------------------------------------------------------
module gpq_store #(
  parameter  int CONTROLLER_COUNT = 4,
  localparam int PA_DEPTH = CONTROLLER_COUNT * 6,
  localparam int DL_DEPTH = CONTROLLER_COUNT * 24,
  localparam int PA_AW    = $clog2(PA_DEPTH),
  localparam int DL_AW    = $clog2(DL_DEPTH)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     pa_rd,
  input  logic                     pa_we,
  input  logic [PA_AW-1:0]         pa_addr,
  input  logic signed [15:0]       pa_wdata,
  output logic signed [15:0]       pa_rdata,
  input  logic                     dl_rd,
  input  logic                     dl_we,
  input  logic [DL_AW-1:0]         dl_addr,
  input  logic [31:0]              dl_wdata,
  output logic [31:0]              dl_rdata
);
  import gpq_pkg::*;

  logic signed [15:0] pa_mem [PA_DEPTH];
  logic [PA_DEPTH-1:0] pa_vld_r;
  logic signed [15:0] pa_data_r;
  logic               pa_rvld_r;
  logic [31:0]        dl_mem [DL_DEPTH];
  logic [31:0]        dl_data_r;

  // Axis history memory.
  always_ff @(posedge clk) begin
    if (pa_we) begin
      pa_mem[pa_addr] <= pa_wdata;
    end
    if (pa_rd) begin
      pa_data_r <= pa_mem[pa_addr];
    end
  end

  // Written marks of the axis history, cleared at reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pa_vld_r  <= '0;
      pa_rvld_r <= 1'b0;
    end else begin
      if (pa_we) begin
        pa_vld_r[pa_addr] <= 1'b1;
      end
      if (pa_rd) begin
        pa_rvld_r <= pa_vld_r[pa_addr];
      end
    end
  end

  assign pa_rdata = pa_rvld_r ? pa_data_r : 16'sd0;

  // Repeat deadline memory.
  always_ff @(posedge clk) begin
    if (dl_we) begin
      dl_mem[dl_addr] <= dl_wdata;
    end
    if (dl_rd) begin
      dl_data_r <= dl_mem[dl_addr];
    end
  end

  assign dl_rdata = dl_data_r;

endmodule

>>> hdl/gpq_emit.sv
// ----------------------------------------------------------------------------
// gpq_emit: event holding stage and output register
// Holds the newest event back until the next one, or the end of the sample,
// shows whether it is the last one of its sample.
// ----------------------------------------------------------------------------
module gpq_emit (
  input  logic                clk,
  input  logic                rst_n,
  input  gpq_pkg::emit_req_t  req,
  output gpq_pkg::emit_sts_t  sts,
  input  logic                out_stall,
  output logic                out_valid,
  output gpq_pkg::event_t     out_evt
);
  import gpq_pkg::*;

  event_t pend_r, pend_nxt;
  logic   pend_v_r, pend_v_nxt;
  event_t out_r, out_nxt;
  logic   out_valid_r, out_valid_nxt;

  // Room for a new event and for the final one.
  assign sts.out_free = !out_valid_r || !out_stall;
  assign sts.push_ok  = !pend_v_r || sts.out_free;

  // A push moves the held event out; the end of a sample flushes it, or a no-event when none is held, as last.
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    pend_nxt      = pend_r;
    pend_v_nxt    = pend_v_r;
    if (req.push) begin
      if (pend_v_r) begin
        out_nxt       = pend_r;
        out_valid_nxt = 1'b1;
      end
      pend_nxt   = req.evt;
      pend_v_nxt = 1'b1;
    end else if (req.fin) begin
      out_nxt       = pend_v_r ? pend_r : req.evt;
      out_nxt.last  = 1'b1;
      out_valid_nxt = 1'b1;
      pend_v_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_evt   = out_r;

endmodule
